// File: rtl/tcw_pkg.sv
// Shared types and constants of the text console character writer.
package tcw_pkg;

  localparam int unsigned ROW_CELLS_DEF = 80;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [0:0] REG_TEXT_COLOR = 1'b0;
  localparam logic [7:0] TEXT_COLOR_RST = 8'd7;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  typedef enum logic [2:0] {
    OP_PRINT,
    OP_NEWLINE,
    OP_RETURN,
    OP_BACKSPACE,
    OP_NUL
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] char_code;
  } item_t;

endpackage

// File: rtl/tcw_if.sv
// Handshake interfaces for the character input and the cell write result channels.
interface tcw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface tcw_out_if;
  logic        valid;
  logic        ready;
  logic        cell_write;
  logic [15:0] cell_index;
  logic [7:0]  char_out;
  logic [7:0]  attr_out;
  logic [15:0] cursor_out;

  modport source (
    output valid, output cell_write, output cell_index, output char_out,
    output attr_out, output cursor_out, input ready
  );
  modport sink (
    input valid, input cell_write, input cell_index, input char_out,
    input attr_out, input cursor_out, output ready
  );
endinterface

// File: rtl/text_console_char_writer.sv
// Top level of the text console character writer with its register port.
//
//   channel   direction  transfer
//   in_ch     in         one character byte (char_code)
//   out_ch    out        cell write flag, cell index, character, attribute, cursor
//   apb       in/out     text_color register at byte address 0
//
// One character per cycle is sustained while out_ch is ready; each result passes the input
// register, the queue and the output register before its transfer on out_ch.
// The cursor update is one add and compare on a tracked column and row start.
// Reset clears the cursor to 0 and sets text_color to 7.
// Each side may stall on its own; the two-entry queue absorbs the difference.
module text_console_char_writer #(
  parameter int unsigned ROW_CELLS = tcw_pkg::ROW_CELLS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  tcw_in_if.sink                       in_ch,
  tcw_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tcw_pkg::PADDR_W-1:0]  paddr,
  input  logic [tcw_pkg::PDATA_W-1:0]  pwdata,
  output logic [tcw_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import tcw_pkg::*;

  logic       f_valid;
  logic       f_ready;
  item_t      f_item;
  logic       q_valid;
  logic       q_ready;
  item_t      q_item;
  logic [7:0] text_color;
  logic       sel_color;

  assign pready    = 1'b1;
  assign sel_color = (paddr[PADDR_W-1:2] == REG_TEXT_COLOR);
  assign prdata    = sel_color ? {{(PDATA_W-8){1'b0}}, text_color} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= TEXT_COLOR_RST;
    end else if (psel && penable && pwrite && pready && sel_color) begin
      text_color <= pwdata[7:0];
    end
  end

  tcw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  tcw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  tcw_back #(
    .ROW_CELLS (ROW_CELLS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .text_color (text_color),
    .out_ch     (out_ch)
  );

endmodule

// File: rtl/tcw_front.sv
// Front stage: accepts character bytes and classifies them into operations.
module tcw_front (
  input  logic           clk,
  input  logic           rst,
  tcw_in_if.sink         in_ch,
  output logic           item_valid,
  input  logic           item_ready,
  output tcw_pkg::item_t item
);
  import tcw_pkg::*;

  logic  vld;
  item_t held;
  op_t   op_class;

  always_comb begin
    case (in_ch.char_code)
      CH_NEWLINE:   op_class = OP_NEWLINE;
      CH_RETURN:    op_class = OP_RETURN;
      CH_BACKSPACE: op_class = OP_BACKSPACE;
      CH_NUL:       op_class = OP_NUL;
      default:      op_class = OP_PRINT;
    endcase
  end

  assign in_ch.ready = !vld || item_ready;
  assign item_valid  = vld;
  assign item        = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ch.ready) begin
      vld <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      held.op        <= op_class;
      held.char_code <= in_ch.char_code;
    end
  end

endmodule

// File: rtl/tcw_queue.sv
// Two-entry queue between the classifying front and the cursor engine.
module tcw_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  tcw_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output tcw_pkg::item_t pop_item
);
  import tcw_pkg::*;

  item_t       mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// File: rtl/tcw_back.sv
// Cursor engine: tracks cursor, column and row start and registers each result.
module tcw_back #(
  parameter int unsigned ROW_CELLS = tcw_pkg::ROW_CELLS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  tcw_pkg::item_t q_item,
  input  logic [7:0]     text_color,
  tcw_out_if.source      out_ch
);
  import tcw_pkg::*;

  localparam int unsigned COL_W = (ROW_CELLS > 1) ? $clog2(ROW_CELLS) : 1;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(ROW_CELLS - 1);
  localparam logic [15:0] ROW_STEP = 16'(ROW_CELLS);

  logic [15:0]      cursor;
  logic [15:0]      base;
  logic [COL_W-1:0] col;
  logic [15:0]      cursor_next;
  logic [15:0]      base_next;
  logic [COL_W-1:0] col_next;
  logic             wr;
  logic [15:0]      idx;
  logic [7:0]       chr;
  logic [16:0]      row_sum;
  logic             out_vld;
  logic             pop;

  assign q_ready      = !out_vld || out_ch.ready;
  assign pop          = q_valid && q_ready;
  assign out_ch.valid = out_vld;
  assign row_sum      = {1'b0, base} + {1'b0, ROW_STEP};

  always_comb begin
    cursor_next = cursor;
    base_next   = base;
    col_next    = col;
    wr          = 1'b0;
    idx         = '0;
    chr         = '0;
    case (q_item.op)
      OP_NEWLINE: begin
        cursor_next = row_sum[15:0];
        if (row_sum[16]) begin
          base_next = '0;
          col_next  = COL_W'(row_sum[15:0]);
        end else begin
          base_next = row_sum[15:0];
          col_next  = '0;
        end
      end
      OP_RETURN: begin
        cursor_next = base;
        col_next    = '0;
      end
      OP_BACKSPACE: begin
        if (cursor != 16'd0) begin
          cursor_next = cursor - 16'd1;
          wr          = 1'b1;
          idx         = cursor - 16'd1;
          chr         = CH_SPACE;
          if (col == '0) begin
            col_next  = COL_LAST;
            base_next = base - ROW_STEP;
          end else begin
            col_next = col - COL_W'(1);
          end
        end
      end
      OP_PRINT: begin
        wr          = 1'b1;
        idx         = cursor;
        chr         = q_item.char_code;
        cursor_next = cursor + 16'd1;
        if (cursor == 16'hFFFF) begin
          base_next = '0;
          col_next  = '0;
        end else if (col == COL_LAST) begin
          base_next = cursor + 16'd1;
          col_next  = '0;
        end else begin
          col_next = col + COL_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
      cursor  <= '0;
      base    <= '0;
      col     <= '0;
    end else begin
      if (q_ready) begin
        out_vld <= q_valid;
      end
      if (pop) begin
        cursor <= cursor_next;
        base   <= base_next;
        col    <= col_next;
      end
    end
    if (pop) begin
      out_ch.cell_write <= wr;
      out_ch.cell_index <= idx;
      out_ch.char_out   <= chr;
      out_ch.attr_out   <= wr ? text_color : 8'd0;
      out_ch.cursor_out <= cursor_next;
    end
  end

  a_cursor_split: assert property (@(posedge clk) disable iff (rst)
    cursor == base + 16'(col))
    else $error("cursor does not equal row start plus column");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    32'(col) < ROW_CELLS)
    else $error("column beyond row width");

  a_print_step: assert property (@(posedge clk) disable iff (rst)
    pop && q_item.op == OP_PRINT |=> cursor == $past(cursor) + 16'd1)
    else $error("printable character did not advance the cursor");

  a_result_cursor: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_ch.cursor_out == cursor)
    else $error("result cursor differs from the cursor register");

endmodule

// File: tb/tb_text_console_char_writer.sv
`timescale 1ns / 100ps
// Self-checking testbench for the text console character writer, with a cursor predictor.
module tb_text_console_char_writer;
  import tcw_pkg::*;

  localparam logic [PADDR_W-1:0] COLOR_ADDR = {REG_TEXT_COLOR, 2'b00};
  localparam logic [PADDR_W-1:0] SPARE_ADDR = {~REG_TEXT_COLOR, 2'b00};

  typedef struct {
    logic        cell_write;
    logic [15:0] cell_index;
    logic [7:0]  char_out;
    logic [7:0]  attr_out;
    logic [15:0] cursor_out;
  } cell_result_t;

  class cell_write_book;
    logic [15:0]  cursor;
    logic [7:0]   text_color;
    cell_result_t due_cells[$];
    int unsigned  errors;

    function new();
      cursor = '0;
      text_color = TEXT_COLOR_RST;
      errors = 0;
    endfunction

    function void set_reg(int unsigned index, logic [31:0] value);
      if (index == REG_TEXT_COLOR) begin
        text_color = value[7:0];
      end
    endfunction

    function op_t classify(logic [7:0] c);
      case (c)
        CH_NEWLINE:   return OP_NEWLINE;
        CH_RETURN:    return OP_RETURN;
        CH_BACKSPACE: return OP_BACKSPACE;
        CH_NUL:       return OP_NUL;
        default:      return OP_PRINT;
      endcase
    endfunction

    function void note_char(logic [7:0] c);
      cell_result_t r;
      int unsigned  row;
      int unsigned  next;
      r = '{default: '0};
      row = cursor / ROW_CELLS_DEF;
      next = cursor;
      case (classify(c))
        OP_NEWLINE: next = (row + 1) * ROW_CELLS_DEF;
        OP_RETURN:  next = row * ROW_CELLS_DEF;
        OP_BACKSPACE: begin
          if (cursor != 0) begin
            next = cursor - 1;
            r.cell_write = 1'b1;
            r.cell_index = next[15:0];
            r.char_out = CH_SPACE;
            r.attr_out = text_color;
          end
        end
        OP_NUL: ;
        default: begin
          r.cell_write = 1'b1;
          r.cell_index = cursor;
          r.char_out = c;
          r.attr_out = text_color;
          next = cursor + 1;
        end
      endcase
      cursor = next[15:0];
      r.cursor_out = cursor;
      due_cells.push_back(r);
    endfunction

    function void match(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_cell(cell_result_t got);
      cell_result_t want;
      if (due_cells.size() == 0) begin
        $display("%0t: unexpected result, expected none, got cursor 0x%0h", $time,
                 got.cursor_out);
        errors++;
        return;
      end
      want = due_cells.pop_front();
      match("cell_write", 16'(want.cell_write), 16'(got.cell_write));
      match("cell_index", want.cell_index, got.cell_index);
      match("char_out", 16'(want.char_out), 16'(got.char_out));
      match("attr_out", 16'(want.attr_out), 16'(got.attr_out));
      match("cursor_out", want.cursor_out, got.cursor_out);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  bit                 calm = 1'b0;
  cell_write_book     book;

  tcw_in_if  in_if ();
  tcw_out_if out_if ();

  text_console_char_writer dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_if.ready <= calm || ($urandom_range(0, 99) >= 34);
  end

  always @(posedge clk) begin
    if (!rst && out_if.valid && out_if.ready) begin
      book.check_cell(cell_result_t'{out_if.cell_write, out_if.cell_index, out_if.char_out,
                                     out_if.attr_out, out_if.cursor_out});
    end
  end

  function automatic logic [7:0] pick_char(int unsigned nl_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < nl_pct) return CH_NEWLINE;
    roll = $urandom_range(0, 99);
    if (roll < 10) return CH_RETURN;
    if (roll < 25) return CH_BACKSPACE;
    if (roll < 30) return CH_NUL;
    if (roll < 40) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(32, 255));
  endfunction

  task automatic send_char(input logic [7:0] c);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 34) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.char_code <= c;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    book.note_char(c);
  endtask

  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (book.due_cells.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    book.set_reg(addr >> 2, data);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic color_check();
    logic [31:0] seen;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= COLOR_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    seen = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (seen !== {24'h0, book.text_color}) begin
      $display("%0t: text_color read mismatch, expected 0x%0h, got 0x%0h", $time,
               book.text_color, seen);
      book.errors++;
    end
  endtask

  task automatic climb(input logic [15:0] top);
    int unsigned n;
    n = 0;
    while (book.cursor < top && n < 3000) begin
      send_char(pick_char(90));
      n++;
    end
  endtask

  initial begin
    logic [7:0] opening [25] = '{
      CH_BACKSPACE, CH_NUL, CH_RETURN, CH_NEWLINE, CH_BACKSPACE, 8'h41, 8'hFF, 8'h01,
      CH_RETURN, CH_BACKSPACE, CH_NEWLINE, CH_BACKSPACE, 8'h7F, CH_SPACE, CH_NUL, 8'h07,
      8'h09, 8'h0B, 8'h0C, 8'h0E, 8'h80, CH_RETURN, CH_NEWLINE, CH_NEWLINE, CH_BACKSPACE
    };
    book = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.char_code = '0;
    out_if.ready = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    color_check();
    foreach (opening[i]) send_char(opening[i]);

    settle();
    reg_write(COLOR_ADDR, 32'h0000_0000);
    reg_write(SPARE_ADDR, 32'hFFFF_FFFF);
    color_check();
    for (int i = 0; i < 150; i++) begin
      if (i == 75) settle();
      send_char(pick_char(12));
    end

    // Climb to the last rows without stalls, then wrap by newline from the last row.
    settle();
    reg_write(COLOR_ADDR, 32'h0000_00FF);
    calm = 1'b1;
    climb(16'hFFA0);
    calm = 1'b0;
    while (book.cursor < 16'hFFF4) send_char(8'($urandom_range(32, 255)));
    send_char(CH_RETURN);
    send_char(CH_BACKSPACE);
    send_char(8'($urandom_range(32, 255)));
    send_char(CH_NEWLINE);

    settle();
    reg_write(COLOR_ADDR, $urandom());
    color_check();
    for (int i = 0; i < 40; i++) send_char(pick_char(20));

    settle();
    if (book.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("%0t: timeout with %0d results outstanding", $time, book.due_cells.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
